// ===== sv/bffa_pkg.sv =====
// shared types and constants for the bitmap first-fit allocator
// no dependencies; imported by bffa_ctrl, bffa_dp and the top level
package bffa_pkg;

	localparam logic [3:0]  SHIFT_MIN   = 4'd6;
	localparam logic [3:0]  SHIFT_MAX   = 4'd12;
	localparam logic [3:0]  SHIFT_RESET = 4'd12;
	localparam logic [24:0] USED_MAX    = 25'h1FFFFFF;
	localparam logic        KIND_FREE   = 1'b1;

	typedef enum logic [3:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_SETUP1,
		ST_SETUP2,
		ST_DECIDE,
		ST_FREE_RUN,
		ST_SCAN_START,
		ST_SCAN_RD,
		ST_SCAN_CHK,
		ST_MARK,
		ST_FIN_OK,
		ST_FIN_FAIL,
		ST_FIN_ZERO,
		ST_FIN_FREE,
		ST_DONE
	} state_t;

	typedef enum logic [1:0] {
		RES_OK,
		RES_FAIL,
		RES_ZERO,
		RES_FREE
	} res_t;

	typedef struct packed {
		logic capture;
		logic setup1;
		logic setup2;
		logic adv;
		logic scan_init;
		logic skip;
		logic wr_en;
		logic wr_val;
		logic fin_en;
		res_t fin;
		logic load_out;
	} cmd_t;

	typedef struct packed {
		logic is_free;
		logic zero_size;
		logic too_big;
		logic no_room;
		logic bit_free;
		logic run_last;
		logic free_done;
		logic clear_last;
		logic out_busy;
	} status_t;

endpackage

// ===== sv/bffa_ctrl.sv =====
// controller state machine of the allocator
// depends on bffa_pkg; drives commands into bffa_dp
module bffa_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	input  bffa_pkg::status_t st,
	output bffa_pkg::cmd_t    cmd,
	output logic              in_stall
);
	import bffa_pkg::*;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_CLEAR:      if (st.clear_last) state_d = ST_IDLE;
			ST_IDLE:       if (in_valid) state_d = ST_SETUP1;
			ST_SETUP1:     state_d = ST_SETUP2;
			ST_SETUP2:     state_d = ST_DECIDE;
			ST_DECIDE: begin
				if (st.is_free) state_d = ST_FREE_RUN;
				else if (st.zero_size) state_d = ST_FIN_ZERO;
				else if (st.too_big) state_d = ST_FIN_FAIL;
				else state_d = ST_SCAN_START;
			end
			ST_FREE_RUN:   if (st.free_done) state_d = ST_FIN_FREE;
			ST_SCAN_START: state_d = st.no_room ? ST_FIN_FAIL : ST_SCAN_RD;
			ST_SCAN_RD:    state_d = ST_SCAN_CHK;
			ST_SCAN_CHK: begin
				if (!st.bit_free) state_d = ST_SCAN_START;
				else if (st.run_last) state_d = ST_MARK;
				else state_d = ST_SCAN_RD;
			end
			ST_MARK:       if (st.run_last) state_d = ST_FIN_OK;
			ST_FIN_OK, ST_FIN_FAIL, ST_FIN_ZERO, ST_FIN_FREE: state_d = ST_DONE;
			ST_DONE:       if (!st.out_busy) state_d = ST_IDLE;
			default:       state_d = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.fin = RES_FAIL;
		in_stall = 1'b1;
		unique case (state_q)
			ST_CLEAR: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_val = 1'b1;
				cmd.adv    = 1'b1;
			end
			ST_IDLE: begin
				in_stall    = 1'b0;
				cmd.capture = in_valid;
			end
			ST_SETUP1: cmd.setup1 = 1'b1;
			ST_SETUP2: cmd.setup2 = 1'b1;
			ST_DECIDE: ;
			ST_FREE_RUN: begin
				if (!st.free_done) begin
					cmd.wr_en  = 1'b1;
					cmd.wr_val = 1'b1;
					cmd.adv    = 1'b1;
				end
			end
			ST_SCAN_START: cmd.scan_init = !st.no_room;
			ST_SCAN_RD: ;
			ST_SCAN_CHK: begin
				if (!st.bit_free) cmd.skip = 1'b1;
				else if (st.run_last) cmd.scan_init = 1'b1;
				else cmd.adv = 1'b1;
			end
			ST_MARK: begin
				cmd.wr_en  = 1'b1;
				cmd.wr_val = 1'b0;
				cmd.adv    = 1'b1;
			end
			ST_FIN_OK: begin
				cmd.fin_en = 1'b1;
				cmd.fin    = RES_OK;
			end
			ST_FIN_FAIL: begin
				cmd.fin_en = 1'b1;
				cmd.fin    = RES_FAIL;
			end
			ST_FIN_ZERO: begin
				cmd.fin_en = 1'b1;
				cmd.fin    = RES_ZERO;
			end
			ST_FIN_FREE: begin
				cmd.fin_en = 1'b1;
				cmd.fin    = RES_FREE;
			end
			ST_DONE: cmd.load_out = !st.out_busy;
			default: ;
		endcase
	end

endmodule

// ===== sv/bffa_dp.sv =====
// datapath of the allocator: bitmap memory, item registers, counters, result register
// depends on bffa_pkg; commanded by bffa_ctrl
module bffa_dp #(
	parameter int UNITS = 4096
) (
	input  logic              clk,
	input  logic              arst_n,
	input  bffa_pkg::cmd_t    cmd,
	output bffa_pkg::status_t st,
	input  logic              cfg_wen,
	input  logic [3:0]        cfg_wdata,
	input  logic              kind,
	input  logic [24:0]       request_bytes,
	input  logic [4:0]        align_log2,
	input  logic [23:0]       free_offset,
	output logic              out_valid,
	input  logic              out_stall,
	output logic              ok,
	output logic [23:0]       offset_bytes,
	output logic [24:0]       granted_bytes,
	output logic [24:0]       used_total
);
	import bffa_pkg::*;

	localparam int AW = (UNITS > 1) ? $clog2(UNITS) : 1;
	localparam int CW = $clog2(UNITS + 1) + 1;
	localparam logic [33:0] UNITS_W = 34'(UNITS);
	localparam logic [CW-1:0] UNITS_C = CW'(UNITS);
	localparam logic [CW-1:0] NEXT_CAP = CW'(1) << (CW - 1);

	logic mem [UNITS];
	logic rdata_q;

	logic [3:0]    shift_cfg_q;
	logic          kind_q;
	logic [24:0]   size_q;
	logic [4:0]    alog_q;
	logic [23:0]   foff_q;
	logic [32:0]   asize_q;
	logic [CW-1:0] req_q;
	logic          too_big_q;
	logic [4:0]    sl_q;
	logic [CW-1:0] s_q;
	logic [CW-1:0] u_q;
	logic [CW-1:0] end_q;
	logic [24:0]   used_q;
	logic          pend_ok_q;
	logic [23:0]   pend_off_q;
	logic [24:0]   pend_gr_q;
	logic          out_valid_q;
	logic          ok_q;
	logic [23:0]   off_q;
	logic [24:0]   gr_q;
	logic [24:0]   tot_q;

	logic [3:0]    sh;
	logic [32:0]   am1, asize_d, unit_m1, req_full, num_full;
	logic [33:0]   end_full;
	logic [23:0]   start_full;
	logic [CW:0]   run_end;
	logic [CW-1:0] next_s;
	logic [CW-1:0] u_hi;
	logic [31:0]   off_full;
	logic [33:0]   used_sum;

	// effective unit shift saturates into the legal range
	always_comb begin
		if (shift_cfg_q < SHIFT_MIN) sh = SHIFT_MIN;
		else if (shift_cfg_q > SHIFT_MAX) sh = SHIFT_MAX;
		else sh = shift_cfg_q;
	end

	always_comb begin
		am1        = (33'd1 << alog_q) - 33'd1;
		asize_d    = ((33'(size_q) + am1) >> alog_q) << alog_q;
		unit_m1    = (33'd1 << sh) - 33'd1;
		req_full   = (asize_q + unit_m1) >> sh;
		num_full   = (33'(size_q) + unit_m1) >> sh;
		start_full = foff_q >> sh;
		end_full   = 34'(start_full) + 34'(num_full);
		run_end    = (CW + 1)'(s_q) + (CW + 1)'(req_q);
		u_hi       = u_q >> sl_q;
		if (sl_q >= 5'(CW - 1)) next_s = NEXT_CAP;
		else next_s = (u_hi + CW'(1)) << sl_q;
		off_full   = 32'(s_q) << sh;
		used_sum   = 34'(used_q) + 34'(asize_q);
	end

	always_ff @(posedge clk) begin
		if (cmd.wr_en) mem[u_q[AW-1:0]] <= cmd.wr_val;
		rdata_q <= mem[u_q[AW-1:0]];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			shift_cfg_q <= SHIFT_RESET;
			u_q         <= '0;
			used_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_wen) shift_cfg_q <= cfg_wdata;
			if (cmd.adv) u_q <= u_q + CW'(1);
			else if (cmd.scan_init) u_q <= s_q;
			else if (cmd.setup2) u_q <= (34'(start_full) > UNITS_W) ? UNITS_C : CW'(start_full);
			if (cmd.fin_en) begin
				case (cmd.fin)
					RES_OK:   used_q <= (used_sum > 34'(USED_MAX)) ? USED_MAX : used_sum[24:0];
					RES_FREE: used_q <= (used_q > size_q) ? used_q - size_q : '0;
					default:  ;
				endcase
			end
			if (cmd.load_out) out_valid_q <= 1'b1;
			else if (!out_stall) out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			kind_q <= kind;
			size_q <= request_bytes;
			alog_q <= align_log2;
			foff_q <= free_offset;
		end
		if (cmd.setup1) asize_q <= asize_d;
		if (cmd.setup2) begin
			too_big_q <= (34'(req_full) > UNITS_W);
			req_q     <= req_full[CW-1:0];
			sl_q      <= (alog_q > 5'(sh)) ? alog_q - 5'(sh) : 5'd0;
			s_q       <= '0;
			end_q     <= (end_full > UNITS_W) ? UNITS_C : end_full[CW-1:0];
		end
		if (cmd.skip) s_q <= next_s;
		if (cmd.fin_en) begin
			case (cmd.fin)
				RES_OK: begin
					pend_ok_q  <= 1'b1;
					pend_off_q <= off_full[23:0];
					pend_gr_q  <= asize_q[24:0];
				end
				RES_FAIL: begin
					pend_ok_q  <= 1'b0;
					pend_off_q <= '0;
					pend_gr_q  <= '0;
				end
				default: begin
					pend_ok_q  <= 1'b1;
					pend_off_q <= '0;
					pend_gr_q  <= '0;
				end
			endcase
		end
		if (cmd.load_out) begin
			ok_q  <= pend_ok_q;
			off_q <= pend_off_q;
			gr_q  <= pend_gr_q;
			tot_q <= used_q;
		end
	end

	always_comb begin
		st.is_free    = (kind_q == KIND_FREE);
		st.zero_size  = (size_q == '0);
		st.too_big    = too_big_q;
		st.no_room    = (run_end > (CW + 1)'(UNITS));
		st.bit_free   = rdata_q;
		st.run_last   = ((CW + 1)'(u_q) == run_end - (CW + 1)'(1));
		st.free_done  = (u_q >= end_q);
		st.clear_last = (u_q == UNITS_C - CW'(1));
		st.out_busy   = out_valid_q && out_stall;
	end

	assign out_valid     = out_valid_q;
	assign ok            = ok_q;
	assign offset_bytes  = off_q;
	assign granted_bytes = gr_q;
	assign used_total    = tot_q;

endmodule

// ===== sv/bitmap_first_fit_unit_allocator_unit.sv =====
// top level of the bitmap first-fit allocator: joins controller and datapath
// depends on bffa_pkg, bffa_ctrl and bffa_dp
//
//  channel  direction  handshake              payload
//  in       sink       in_valid / in_stall    kind, request_bytes, align_log2, free_offset
//  out      source     out_valid / out_stall  ok, offset_bytes, granted_bytes, used_total
//  cfg      sink       cfg_wen                cfg_wdata (unit_shift)
//
// one item at a time; the bitmap is a one-bit-wide memory walked one unit per step
// allocate: setup, room check per start, read then check per unit, write per unit marked, finish
// free: setup, one write per unit released, finish; zero size or too big: setup, then finish
// after reset a clearing pass sets every unit free; no item is taken meanwhile
// a finished result sits in the output register while the next item is accepted
// a result still stalled in the output register holds the next one in its finish state
module bitmap_first_fit_unit_allocator_unit #(
	parameter int UNITS = 4096
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_wen,
	input  logic [3:0]  cfg_wdata,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        kind,
	input  logic [24:0] request_bytes,
	input  logic [4:0]  align_log2,
	input  logic [23:0] free_offset,
	output logic        out_valid,
	input  logic        out_stall,
	output logic        ok,
	output logic [23:0] offset_bytes,
	output logic [24:0] granted_bytes,
	output logic [24:0] used_total
);
	import bffa_pkg::*;

	// command and status between the two halves
	cmd_t    cmd;
	status_t st;

	// sequencer: clearing pass, scan, marking, release, result transfer
	bffa_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.st       (st),
		.cmd      (cmd),
		.in_stall (in_stall)
	);

	// bitmap, counters, used-byte total and output register
	bffa_dp #(
		.UNITS (UNITS)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.cmd           (cmd),
		.st            (st),
		.cfg_wen       (cfg_wen),
		.cfg_wdata     (cfg_wdata),
		.kind          (kind),
		.request_bytes (request_bytes),
		.align_log2    (align_log2),
		.free_offset   (free_offset),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.ok            (ok),
		.offset_bytes  (offset_bytes),
		.granted_bytes (granted_bytes),
		.used_total    (used_total)
	);

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps
// self-checking testbench for bitmap_first_fit_unit_allocator_unit
// depends on bffa_pkg and the allocator rtl; carries its own bitmap model of the allocator
module testbench;
	import bffa_pkg::*;

	localparam int      NUM_UNITS  = 4096;
	localparam longint  CYCLE_CAP  = 100_000_000;
	localparam int      PHASE_LEN  = 180;
	localparam logic    KIND_ALLOC = 1'b0;
	localparam logic [24:0] BLOCK_ALL = 25'd16777216;

	// one expected or observed result transfer
	typedef struct packed {
		logic        ok;
		logic [23:0] off;
		logic [24:0] gr;
		logic [24:0] used;
	} alloc_res_t;

	// one directed stimulus row; chk marks rows whose result is typed in
	typedef struct packed {
		logic        kind;
		logic [24:0] sz;
		logic [4:0]  al;
		logic [23:0] fo;
		logic        chk;
		alloc_res_t  res;
	} dir_row_t;

	// a granted region still held, so it can be released later
	typedef struct packed {
		logic [23:0] off;
		logic [24:0] gr;
	} region_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_wen = 1'b0;
	logic [3:0]  cfg_wdata = 4'd0;
	logic        in_valid = 1'b0;
	logic        in_stall;
	logic        kind = 1'b0;
	logic [24:0] request_bytes = '0;
	logic [4:0]  align_log2 = '0;
	logic [23:0] free_offset = '0;
	logic        out_valid;
	logic        out_stall = 1'b0;
	logic        ok;
	logic [23:0] offset_bytes;
	logic [24:0] granted_bytes;
	logic [24:0] used_total;

	// model state: free bitmap, used-byte count and the unit shift register
	bit          unit_free [NUM_UNITS];
	logic [24:0] used_count;
	logic [3:0]  shift_reg;

	alloc_res_t  pending_res [$];
	region_t     held [$];
	int          fail_count = 0;
	longint      cycle_count = 0;
	int          snd_idle = 28;
	int          rcv_idle = 54;

	// directed rows run with the reset unit size of 4 KiB
	dir_row_t dir_tab [20] = '{
		// zero-size allocate changes nothing
		'{KIND_ALLOC, 25'd0, 5'd0, 24'd0, 1'b1, '{1'b1, 24'd0, 25'd0, 25'd0}},
		'{KIND_ALLOC, 25'd1, 5'd0, 24'd0, 1'b1, '{1'b1, 24'd0, 25'd1, 25'd1}},
		'{KIND_ALLOC, 25'd4096, 5'd12, 24'd0, 1'b1, '{1'b1, 24'd4096, 25'd4096, 25'd4097}},
		// whole block no longer fits
		'{KIND_ALLOC, BLOCK_ALL, 5'd0, 24'd0, 1'b1, '{1'b0, 24'd0, 25'd0, 25'd4097}},
		// alignment as large as the block, then past it
		'{KIND_ALLOC, 25'd1, 5'd24, 24'd0, 1'b1, '{1'b0, 24'd0, 25'd0, 25'd4097}},
		'{KIND_ALLOC, 25'd1, 5'd31, 24'd0, 1'b1, '{1'b0, 24'd0, 25'd0, 25'd4097}},
		'{KIND_FREE, 25'd1, 5'd0, 24'd0, 1'b1, '{1'b1, 24'd0, 25'd0, 25'd4096}},
		// free running past the last unit, count saturates at zero
		'{KIND_FREE, BLOCK_ALL, 5'd0, 24'hFFFFFF, 1'b1, '{1'b1, 24'd0, 25'd0, 25'd0}},
		'{KIND_FREE, BLOCK_ALL, 5'd31, 24'd0, 1'b1, '{1'b1, 24'd0, 25'd0, 25'd0}},
		'{KIND_ALLOC, BLOCK_ALL, 5'd0, 24'd0, 1'b1, '{1'b1, 24'd0, BLOCK_ALL, BLOCK_ALL}},
		'{KIND_ALLOC, 25'd1, 5'd0, 24'd0, 1'b1, '{1'b0, 24'd0, 25'd0, BLOCK_ALL}},
		'{KIND_FREE, BLOCK_ALL, 5'd0, 24'd0, 1'b1, '{1'b1, 24'd0, 25'd0, 25'd0}},
		'{KIND_ALLOC, 25'd16777215, 5'd0, 24'd0, 1'b1,
			'{1'b1, 24'd0, 25'd16777215, 25'd16777215}},
		'{KIND_FREE, BLOCK_ALL, 5'd0, 24'd0, 1'b1, '{1'b1, 24'd0, 25'd0, 25'd0}},
		// request field all ones is too big
		'{KIND_ALLOC, 25'h1FFFFFF, 5'd0, 24'd0, 1'b1, '{1'b0, 24'd0, 25'd0, 25'd0}},
		'{KIND_FREE, 25'd0, 5'd0, 24'hFFFFFF, 1'b1, '{1'b1, 24'd0, 25'd0, 25'd0}},
		// from here on the model decides
		'{KIND_ALLOC, 25'd100, 5'd13, 24'd0, 1'b0, '0},
		'{KIND_ALLOC, 25'd100, 5'd13, 24'd0, 1'b0, '0},
		'{KIND_ALLOC, 25'd5000, 5'd0, 24'd0, 1'b0, '0},
		'{KIND_FREE, BLOCK_ALL, 5'd0, 24'd0, 1'b0, '0}
	};

	bitmap_first_fit_unit_allocator_unit #(.UNITS(NUM_UNITS)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_wen(cfg_wen), .cfg_wdata(cfg_wdata),
		.in_valid(in_valid), .in_stall(in_stall),
		.kind(kind), .request_bytes(request_bytes),
		.align_log2(align_log2), .free_offset(free_offset),
		.out_valid(out_valid), .out_stall(out_stall),
		.ok(ok), .offset_bytes(offset_bytes),
		.granted_bytes(granted_bytes), .used_total(used_total)
	);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	// first-fit model of one item, updates bitmap and byte count
	task automatic alloc_step(input logic k, input logic [24:0] sz, input logic [4:0] al,
			input logic [23:0] fo, output alloc_res_t r);
		int          sh;
		longint unsigned unit_b, align_b, asize, req, stride, s, kk, st, en;
		longint unsigned total;
		bit          blocked;
		sh = int'((shift_reg < SHIFT_MIN) ? SHIFT_MIN :
			(shift_reg > SHIFT_MAX) ? SHIFT_MAX : shift_reg);
		unit_b = 64'd1 << sh;
		r = '0;
		if (k == KIND_ALLOC) begin
			if (sz == 0) begin
				r.ok = 1'b1;
			end else begin
				align_b = 64'd1 << al;
				asize = ((sz + align_b - 1) >> al) << al;
				req = (asize + unit_b - 1) >> sh;
				stride = (align_b > unit_b) ? (align_b >> sh) : 64'd1;
				s = 0;
				// scan back from the run end, skip past the first used unit found
				while (req <= NUM_UNITS && s + req <= NUM_UNITS) begin
					kk = s + req;
					blocked = 1'b0;
					while (kk > s) begin
						kk--;
						if (!unit_free[kk]) begin
							blocked = 1'b1;
							break;
						end
					end
					if (!blocked) begin
						for (longint unsigned u = s; u < s + req; u++) unit_free[u] = 1'b0;
						total = used_count + asize;
						used_count = (total > USED_MAX) ? USED_MAX : total[24:0];
						r.ok = 1'b1;
						r.off = 24'((s << sh) & 64'hFFFFFF);
						r.gr = 25'(asize);
						break;
					end
					s = (kk / stride + 1) * stride;
				end
			end
		end else begin
			st = 64'(fo) >> sh;
			en = st + ((sz + unit_b - 1) >> sh);
			if (en > NUM_UNITS) en = NUM_UNITS;
			for (longint unsigned u = st; u < en; u++) unit_free[u] = 1'b1;
			used_count = (used_count > sz) ? used_count - sz : 25'd0;
			r.ok = 1'b1;
		end
		r.used = used_count;
	endtask

	// drive one input transfer, keep valid high after it is taken
	task automatic send_item(input logic k, input logic [24:0] sz, input logic [4:0] al,
			input logic [23:0] fo, input logic chk, input alloc_res_t typed);
		alloc_res_t r;
		@(negedge clk);
		while ($urandom_range(0, 99) < snd_idle) begin
			in_valid <= 1'b0;
			@(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		request_bytes <= sz;
		align_log2 <= al;
		free_offset <= fo;
		do @(posedge clk); while (in_stall !== 1'b0);
		alloc_step(k, sz, al, fo, r);
		if (k == KIND_ALLOC && r.ok && r.gr != 0)
			held.insert(held.size(), region_t'{r.off, r.gr});
		pending_res.insert(pending_res.size(), chk ? typed : r);
	endtask

	// drop valid and wait until every result has come out
	task automatic drain;
		@(negedge clk);
		in_valid <= 1'b0;
		while (pending_res.size() != 0) @(posedge clk);
	endtask

	task automatic write_shift(input logic [3:0] v);
		repeat (8) @(negedge clk);
		cfg_wen <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_wen <= 1'b0;
		shift_reg = v;
	endtask

	// one phase: new unit size, clear the block, then a random mix
	task automatic run_phase(input logic [3:0] v, input int s_idle, input int r_idle);
		int          sh;
		int          pick;
		int          idx;
		logic        k;
		logic [24:0] sz;
		logic [4:0]  al;
		logic [23:0] fo;
		drain();
		write_shift(v);
		snd_idle = s_idle;
		rcv_idle = r_idle;
		sh = int'((v < SHIFT_MIN) ? SHIFT_MIN : (v > SHIFT_MAX) ? SHIFT_MAX : v);
		held.delete();
		send_item(KIND_FREE, BLOCK_ALL, 5'd0, 24'd0, 1'b0, '0);
		for (int n = 0; n < PHASE_LEN; n++) begin
			// hold off once per phase until the block has gone quiet
			if (n == PHASE_LEN / 2) drain();
			pick = $urandom_range(0, 99);
			if (held.size() != 0 && (pick < 45 || held.size() > 24)) begin
				// release a region still held, its exact offset and size
				idx = $urandom_range(0, held.size() - 1);
				k = KIND_FREE;
				fo = held[idx].off;
				sz = held[idx].gr;
				al = 5'($urandom_range(0, 31));
				held.delete(idx);
			end else if (pick < 92) begin
				k = KIND_ALLOC;
				sz = 25'($urandom_range(1, 6 << sh));
				al = 5'($urandom_range(0, sh + 2));
				fo = 24'($urandom);
			end else begin
				// noise over the full field ranges
				k = 1'($urandom_range(0, 1));
				sz = 25'($urandom);
				al = 5'($urandom_range(0, 31));
				fo = 24'($urandom);
			end
			send_item(k, sz, al, fo, 1'b0, '0);
		end
	endtask

	always @(negedge clk) begin
		out_stall <= ($urandom_range(0, 99) < rcv_idle);
	end

	// compare each result transfer against the oldest expectation
	always @(posedge clk) begin
		alloc_res_t e;
		if (arst_n && out_valid === 1'b1 && out_stall == 1'b0) begin
			if (pending_res.size() == 0) begin
				$error("result transfer with nothing expected");
				fail_count++;
			end else begin
				e = pending_res.pop_front();
				if (ok !== e.ok) begin
					$error("ok expected %0d actual %0d", e.ok, ok);
					fail_count++;
				end
				if (offset_bytes !== e.off) begin
					$error("offset_bytes expected %0d actual %0d", e.off, offset_bytes);
					fail_count++;
				end
				if (granted_bytes !== e.gr) begin
					$error("granted_bytes expected %0d actual %0d", e.gr, granted_bytes);
					fail_count++;
				end
				if (used_total !== e.used) begin
					$error("used_total expected %0d actual %0d", e.used, used_total);
					fail_count++;
				end
			end
		end
	end

	// watchdog on total run length
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count > CYCLE_CAP) begin
			$display("testbench failed");
			$finish;
		end
	end

	initial begin
		foreach (unit_free[i]) unit_free[i] = 1'b1;
		used_count = '0;
		shift_reg = SHIFT_RESET;
		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;
		write_shift(4'd12);
		foreach (dir_tab[i])
			send_item(dir_tab[i].kind, dir_tab[i].sz, dir_tab[i].al, dir_tab[i].fo,
				dir_tab[i].chk, dir_tab[i].res);
		// unit sizes cover both ends and both saturating codes
		run_phase(4'd6, 28, 54);
		run_phase(4'd15, 28, 54);
		run_phase(4'd9, 54, 28);
		run_phase(4'd0, 54, 28);
		run_phase(4'd12, 0, 0);
		run_phase(4'd7, 0, 0);
		drain();
		repeat (20) @(posedge clk);
		if (fail_count == 0 && pending_res.size() == 0) begin
			$display("testbench passed");
		end else begin
			$display("testbench failed");
		end
		$finish;
	end

endmodule

// ===== filelist.f =====
sv/bffa_pkg.sv
sv/bffa_ctrl.sv
sv/bffa_dp.sv
sv/bitmap_first_fit_unit_allocator_unit.sv
test/testbench.sv
